// ===== rtl/core/eds_pkg.sv =====
// Package for the explicit diffusion stencil row block.
// Holds the configuration register indexes, datapath widths, the result-queue
// write request type and the saturation function. No dependencies.
package eds_pkg;

    localparam int DATA_W = 32;
    localparam int TERM_W = 44;
    localparam int PROD_W = 68;
    localparam int SUM_W  = 46;
    localparam int COEF_FRAC = 24;

    localparam logic [1:0] CFG_STEP_TAU       = 2'd0;
    localparam logic [1:0] CFG_COEF_DIFFUSION = 2'd1;
    localparam logic [1:0] CFG_COEF_ADVECTION = 2'd2;
    localparam logic [1:0] CFG_COEF_EDGE      = 2'd3;

    localparam logic [DATA_W-1:0] COEF_DIFFUSION_RST = 32'h0040_0000;

    typedef struct packed {
        logic              wr0;
        logic              wr1;
        logic [DATA_W-1:0] val0;
        logic [DATA_W-1:0] val1;
        logic              end0;
        logic              end1;
    } eds_wr_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end
        else if (v[SUM_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/explicit_diffusion_stencil_row.sv =====
// Top level of the explicit diffusion stencil row block: window, coefficient
// registers, two-stage multiply-add datapath and the result queue.
// Depends on eds_pkg and eds_outq.

// The block takes one old-row sample per cycle while in_stall is low and
// returns new-row values in column order, each interior value one column
// late, when its right neighbour arrives. A request passes an operand
// register and a product register with all five coefficient products in
// parallel, and is then written to the result queue. The final column of a
// row of three or more columns yields two results, and the output hands out
// one per cycle while out_stall is low, so in_stall rises when the queue of
// OUT_DEPTH entries (a power of two, at least 8) together with
// the two requests in flight could overflow. Configuration writes are taken
// at any time and should be made while the block is idle.
module explicit_diffusion_stencil_row
    import eds_pkg::*;
#(
    parameter int OUT_DEPTH = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] sample,
    input  logic signed [DATA_W-1:0] source,
    input  logic signed [DATA_W-1:0] left_boundary,
    input  logic                     row_first,
    input  logic                     row_last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] new_value,
    output logic                     row_end
);

    localparam int CNT_W = $clog2(OUT_DEPTH+1);
    localparam int RES_W = CNT_W + 2;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_ONE  = 3'b010,
        PH_RUN  = 3'b100
    } phase_t;

    typedef struct packed {
        logic emit_lb;
        logic emit_int;
        logic emit_edge;
        logic lb_end;
    } flags_t;

    logic [DATA_W-1:0] step_tau_reg, coef_diffusion_reg, coef_advection_reg, coef_edge_reg;

    phase_t                   phase_reg, phase_next;
    logic signed [DATA_W-1:0] left_reg, left_next;
    logic signed [DATA_W-1:0] center_reg, center_next;
    logic signed [DATA_W-1:0] held_reg, held_next;

    logic   in_accept;
    flags_t flags_in;

    logic                     s1_valid_reg;
    flags_t                   s1_flags_reg;
    logic signed [DATA_W-1:0] s1_lb_reg, s1_l_reg, s1_c_reg, s1_r_reg, s1_fh_reg, s1_fs_reg;

    logic                     s2_valid_reg;
    flags_t                   s2_flags_reg;
    logic signed [DATA_W-1:0] s2_lb_reg, s2_c_reg, s2_r_reg;
    logic signed [TERM_W-1:0] s2_tfi_reg, s2_ta_reg, s2_tb_reg, s2_tfe_reg, s2_tc_reg;

    logic signed [DATA_W+2:0] diff2;
    logic signed [DATA_W+2:0] diff1;
    logic signed [DATA_W+2:0] diffe;
    logic signed [PROD_W-1:0] prod_tfi, prod_a, prod_b, prod_tfe, prod_c;

    logic signed [SUM_W-1:0]  int_sum, edge_sum;
    logic signed [DATA_W-1:0] int_val, edge_val;
    eds_wr_t                  wr;

    logic [CNT_W-1:0] q_count;
    logic [RES_W-1:0] reserve;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_tau_reg       <= '0;
            coef_diffusion_reg <= COEF_DIFFUSION_RST;
            coef_advection_reg <= '0;
            coef_edge_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STEP_TAU:       step_tau_reg       <= cfg_data;
                CFG_COEF_DIFFUSION: coef_diffusion_reg <= cfg_data;
                CFG_COEF_ADVECTION: coef_advection_reg <= cfg_data;
                CFG_COEF_EDGE:      coef_edge_reg      <= cfg_data;
                default:            step_tau_reg       <= step_tau_reg;
            endcase
        end
    end

    // Each request reserves two queue entries until it has been written.
    assign reserve = RES_W'(q_count) + RES_W'({s1_valid_reg, 1'b0})
                   + RES_W'({s2_valid_reg, 1'b0}) + RES_W'(2);
    assign in_stall  = (reserve > RES_W'(OUT_DEPTH));
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        center_next = center_reg;
        held_next   = held_reg;
        flags_in    = '0;
        flags_in.lb_end = row_last;
        if (in_accept)
        begin
            if (row_first)
            begin
                flags_in.emit_lb = 1'b1;
                left_next   = '0;
                center_next = sample;
                held_next   = source;
                phase_next  = row_last ? PH_WAIT : PH_ONE;
            end
            else if (phase_reg != PH_WAIT)
            begin
                flags_in.emit_int = (phase_reg == PH_RUN);
                if (row_last)
                begin
                    flags_in.emit_edge = 1'b1;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    left_next   = center_reg;
                    center_next = sample;
                    held_next   = source;
                    phase_next  = PH_RUN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT;
            left_reg     <= '0;
            center_reg   <= '0;
            held_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_flags_reg <= '0;
            s2_valid_reg <= 1'b0;
            s2_flags_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            center_reg   <= center_next;
            held_reg     <= held_next;
            s1_valid_reg <= in_accept
                         && (flags_in.emit_lb || flags_in.emit_int || flags_in.emit_edge);
            s1_flags_reg <= flags_in;
            s2_valid_reg <= s1_valid_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // Operand register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_lb_reg <= left_boundary;
            s1_l_reg  <= left_reg;
            s1_c_reg  <= center_reg;
            s1_r_reg  <= sample;
            s1_fh_reg <= held_reg;
            s1_fs_reg <= source;
        end
    end

    // Products; dropping the low coefficient fraction bits rounds toward minus infinity.
    always_comb
    begin
        diff2 = (DATA_W+3)'(s1_r_reg) - ((DATA_W+3)'(s1_c_reg) <<< 1) + (DATA_W+3)'(s1_l_reg);
        diff1 = (DATA_W+3)'(s1_r_reg) - (DATA_W+3)'(s1_l_reg);
        diffe = (DATA_W+3)'(s1_r_reg) - (DATA_W+3)'(s1_c_reg);
        prod_tfi = $signed({1'b0, step_tau_reg}) * s1_fh_reg;
        prod_a   = $signed({1'b0, coef_diffusion_reg}) * diff2;
        prod_b   = $signed({1'b0, coef_advection_reg}) * diff1;
        prod_tfe = $signed({1'b0, step_tau_reg}) * s1_fs_reg;
        prod_c   = $signed({1'b0, coef_edge_reg}) * diffe;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_lb_reg  <= s1_lb_reg;
            s2_c_reg   <= s1_c_reg;
            s2_r_reg   <= s1_r_reg;
            s2_tfi_reg <= prod_tfi[PROD_W-1:COEF_FRAC];
            s2_ta_reg  <= prod_a[PROD_W-1:COEF_FRAC];
            s2_tb_reg  <= prod_b[PROD_W-1:COEF_FRAC];
            s2_tfe_reg <= prod_tfe[PROD_W-1:COEF_FRAC];
            s2_tc_reg  <= prod_c[PROD_W-1:COEF_FRAC];
        end
    end

    always_comb
    begin
        int_sum  = SUM_W'(s2_c_reg) + SUM_W'(s2_tfi_reg) + SUM_W'(s2_ta_reg) + SUM_W'(s2_tb_reg);
        edge_sum = SUM_W'(s2_r_reg) + SUM_W'(s2_tfe_reg) - SUM_W'(s2_tc_reg);
        int_val  = sat_data(int_sum);
        edge_val = sat_data(edge_sum);

        wr = '0;
        if (s2_flags_reg.emit_lb)
        begin
            wr.wr0  = s2_valid_reg;
            wr.val0 = s2_lb_reg;
            wr.end0 = s2_flags_reg.lb_end;
        end
        else if (s2_flags_reg.emit_int)
        begin
            wr.wr0  = s2_valid_reg;
            wr.val0 = int_val;
            wr.end0 = 1'b0;
            wr.wr1  = s2_valid_reg && s2_flags_reg.emit_edge;
            wr.val1 = edge_val;
            wr.end1 = 1'b1;
        end
        else
        begin
            wr.wr0  = s2_valid_reg && s2_flags_reg.emit_edge;
            wr.val0 = edge_val;
            wr.end0 = 1'b1;
        end
    end

    eds_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .new_value (new_value),
        .row_end   (row_end),
        .count     (q_count)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    a_lb_alone: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags_reg.emit_lb |-> !s1_flags_reg.emit_int && !s1_flags_reg.emit_edge)
        else $error("left boundary request carries stencil results");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && row_first |=> s1_valid_reg && s1_flags_reg.emit_lb)
        else $error("row start did not produce a boundary request");

    a_second_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.wr1 |-> wr.wr0 && wr.end1)
        else $error("second queue write without first or without row end");

endmodule

// ===== rtl/core/eds_outq.sv =====
// Result queue of the stencil row block: takes up to two requests per cycle
// and hands them out one per cycle on the output channel while out_stall is low.
// Depends on eds_pkg for the write request type.
module eds_outq
    import eds_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  eds_wr_t                       wr,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic signed [DATA_W-1:0]      new_value,
    output logic                          row_end,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [DATA_W-1:0] value_mem [DEPTH];
    logic              end_mem   [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [1:0]       n_wr;
    logic             rd;

    assign wr_ptr_plus1 = PTR_W'(wr_ptr_reg + 1'b1);
    assign n_wr = {1'b0, wr.wr0} + {1'b0, wr.wr1};
    assign rd = out_valid && !out_stall;

    assign out_valid = (count_reg != '0);
    assign new_value = value_mem[rd_ptr_reg];
    assign row_end   = end_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(n_wr));
        rd_ptr_next = rd ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(n_wr) - CNT_W'(rd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr0)
        begin
            value_mem[wr_ptr_reg] <= wr.val0;
            end_mem[wr_ptr_reg]   <= wr.end0;
        end
        if (wr.wr1)
        begin
            value_mem[wr_ptr_plus1] <= wr.val1;
            end_mem[wr_ptr_plus1]   <= wr.end1;
        end
    end

endmodule
